/* rtl/core/nct_pkg.sv */
// ----------------------------------------------------------------------------
// nct_pkg
// Shared types and constants for the counter text converter: input style
// codes, character codes, limits and the command passed from front to back.
// ----------------------------------------------------------------------------
package nct_pkg;

  // Input style codes
  localparam logic [2:0] STYLE_DEC      = 3'd0;
  localparam logic [2:0] STYLE_ROM_UP   = 3'd1;
  localparam logic [2:0] STYLE_ROM_LO   = 3'd2;
  localparam logic [2:0] STYLE_LET_UP   = 3'd3;
  localparam logic [2:0] STYLE_LET_LO   = 3'd4;

  // Character codes
  localparam logic [6:0] CH_NUL         = 7'h00;
  localparam logic [6:0] CH_MINUS       = 7'h2D;
  localparam logic [6:0] CH_QMARK       = 7'h3F;
  localparam logic [6:0] CH_ZERO        = 7'h30;
  localparam logic [6:0] LET_UP_BASE    = 7'd64;
  localparam logic [6:0] LET_LO_BASE    = 7'd96;
  localparam logic [6:0] CASE_OFFSET    = 7'd32;

  // Range limits
  localparam logic [31:0] DEC_LIMIT     = 32'd100000;
  localparam logic [31:0] ROM_LIMIT     = 32'd4000;
  localparam logic [31:0] LET_MAX       = 32'd26;

  // Decimal conversion: five BCD digits, two bits shifted in per step
  localparam int DEC_DIGITS = 5;
  localparam int MAG_W      = 32;
  localparam int CONV_STEPS = MAG_W / 2;

  // Command handed from front to back
  typedef struct packed {
    logic                       neg;
    logic [2:0]                 style;
    logic                       dec_big;
    logic                       rom_big;
    logic [6:0]                 let_code;
    logic [DEC_DIGITS-1:0][3:0] digits;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SIGN,
    B_MARK,
    B_DEC,
    B_ROM,
    B_LET,
    B_TERM
  } back_state_t;

endpackage

/* rtl/core/nct_front.sv */
// ----------------------------------------------------------------------------
// nct_front
// Accepts one input word, takes the magnitude, classifies it against the
// style limits and converts it to five BCD digits by shift-and-add-3.
// ----------------------------------------------------------------------------
module nct_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [39:0]   in_tdata,   // [31:0] value, [34:32] style
  output logic          push_valid,
  input  logic          push_ready,
  output nct_pkg::cmd_t push_cmd
);

  localparam int BCD_W = nct_pkg::DEC_DIGITS * 4;
  localparam int DD_W  = BCD_W + nct_pkg::MAG_W;

  nct_pkg::front_state_t state_r, state_nxt;

  logic [nct_pkg::MAG_W-1:0] sh_r;
  logic [BCD_W-1:0]          bcd_r;
  logic [3:0]                cnt_r;
  logic                      neg_r;
  logic [2:0]                style_r;
  logic                      dec_big_r;
  logic                      rom_big_r;
  logic [6:0]                let_r;

  logic [31:0] in_value;
  logic [2:0]  in_style;
  logic [31:0] mag;
  logic [6:0]  let_code;
  logic        accept;
  logic [DD_W-1:0] dd_two;

  // One shift-and-add-3 step over the BCD digits and the binary shifter
  function automatic logic [DD_W-1:0] dd_step(input logic [DD_W-1:0] x);
    logic [DD_W-1:0] y;
    y = x;
    for (int i = 0; i < nct_pkg::DEC_DIGITS; i++) begin
      if (y[nct_pkg::MAG_W + 4*i +: 4] >= 4'd5) begin
        y[nct_pkg::MAG_W + 4*i +: 4] = y[nct_pkg::MAG_W + 4*i +: 4] + 4'd3;
      end
    end
    return {y[DD_W-2:0], 1'b0};
  endfunction

  assign in_value = in_tdata[31:0];
  assign in_style = in_tdata[34:32];
  assign accept   = in_tvalid && in_tready;

  // Magnitude and letter code of the incoming word
  always_comb begin
    mag = in_value[31] ? (32'd0 - in_value) : in_value;
    if (mag > nct_pkg::LET_MAX) begin
      let_code = nct_pkg::CH_QMARK;
    end else if (in_style == nct_pkg::STYLE_LET_UP) begin
      let_code = mag[6:0] + nct_pkg::LET_UP_BASE;
    end else begin
      let_code = mag[6:0] + nct_pkg::LET_LO_BASE;
    end
  end

  assign dd_two = dd_step(dd_step({bcd_r, sh_r}));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nct_pkg::F_IDLE: begin
        if (in_tvalid) state_nxt = nct_pkg::F_CONV;
      end
      nct_pkg::F_CONV: begin
        if (cnt_r == 4'(nct_pkg::CONV_STEPS - 1)) state_nxt = nct_pkg::F_PUSH;
      end
      nct_pkg::F_PUSH: begin
        if (push_ready) state_nxt = nct_pkg::F_IDLE;
      end
      default: state_nxt = nct_pkg::F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready  = 1'b0;
    push_valid = 1'b0;
    case (state_r)
      nct_pkg::F_IDLE: in_tready  = 1'b1;
      nct_pkg::F_PUSH: push_valid = 1'b1;
      default: begin
        in_tready  = 1'b0;
        push_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    push_cmd          = '0;
    push_cmd.neg      = neg_r;
    push_cmd.style    = style_r;
    push_cmd.dec_big  = dec_big_r;
    push_cmd.rom_big  = rom_big_r;
    push_cmd.let_code = let_r;
    push_cmd.digits   = bcd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nct_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Load on accept, shift two bits per cycle while converting
  always_ff @(posedge clk) begin
    if (accept) begin
      sh_r      <= mag;
      bcd_r     <= '0;
      cnt_r     <= '0;
      neg_r     <= in_value[31];
      style_r   <= in_style;
      dec_big_r <= (mag >= nct_pkg::DEC_LIMIT);
      rom_big_r <= (mag >= nct_pkg::ROM_LIMIT);
      let_r     <= let_code;
    end else if (state_r == nct_pkg::F_CONV) begin
      {bcd_r, sh_r} <= dd_two;
      cnt_r         <= cnt_r + 4'd1;
    end
  end

endmodule

/* rtl/core/nct_queue.sv */
// ----------------------------------------------------------------------------
// nct_queue
// Short command queue between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module nct_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  nct_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop,
  output nct_pkg::cmd_t pop_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  nct_pkg::cmd_t    slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Store incoming command
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_cmd;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

/* rtl/core/nct_back.sv */
// ----------------------------------------------------------------------------
// nct_back
// Takes one command at a time and emits its characters, one per output word,
// followed by the terminator word.
// ----------------------------------------------------------------------------
module nct_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  nct_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [15:0]   out_tdata,  // [6:0] char_code, [11:7] position
  output logic          out_tlast   // is_last
);

  localparam logic [1:0] KIND_ONE  = 2'd0;
  localparam logic [1:0] KIND_FIVE = 2'd1;
  localparam logic [1:0] KIND_TEN  = 2'd2;

  nct_pkg::back_state_t state_r, state_nxt;
  nct_pkg::cmd_t        cmd_r, cmd_nxt, sel;
  logic [2:0]           dig_r, dig_nxt;
  logic [1:0]           sub_r, sub_nxt;
  logic [4:0]           pos_r, pos_nxt;

  logic                 out_tvalid_r;
  logic [15:0]          out_tdata_r;
  logic                 out_tlast_r;

  logic                 emit_ok;
  logic                 emit;
  logic [6:0]           ch;
  logic                 last;

  logic [2:0]           dec_top;
  logic [2:0]           rom_top;
  logic                 rom_any;
  logic [2:0]           rom_low;
  logic                 low_any;
  nct_pkg::back_state_t entry_state;
  logic [2:0]           entry_dig;
  logic [3:0]           cur_d;
  logic [6:0]           rom_ch;

  // Length of the Roman pattern for one decimal digit
  function automatic logic [2:0] rom_len(input logic [3:0] d);
    logic [2:0] r;
    case (d)
      4'd1, 4'd5:       r = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: r = 3'd2;
      4'd3, 4'd7:       r = 3'd3;
      4'd8:             r = 3'd4;
      default:          r = 3'd0;
    endcase
    return r;
  endfunction

  // Symbol kind at place k of the pattern for digit d
  function automatic logic [1:0] rom_kind(input logic [3:0] d, input logic [1:0] k);
    logic [1:0] r;
    case (d)
      4'd4:                   r = (k == 2'd0) ? KIND_ONE : KIND_FIVE;
      4'd5, 4'd6, 4'd7, 4'd8: r = (k == 2'd0) ? KIND_FIVE : KIND_ONE;
      4'd9:                   r = (k == 2'd0) ? KIND_ONE : KIND_TEN;
      default:                r = KIND_ONE;
    endcase
    return r;
  endfunction

  // Upper-case letter for a decade and symbol kind
  function automatic logic [6:0] rom_letter(input logic [1:0] idx, input logic [1:0] kind);
    logic [6:0] r;
    case (idx)
      2'd3: r = 7'("M");
      2'd2: r = (kind == KIND_FIVE) ? 7'("D") : (kind == KIND_TEN) ? 7'("M") : 7'("C");
      2'd1: r = (kind == KIND_FIVE) ? 7'("L") : (kind == KIND_TEN) ? 7'("C") : 7'("X");
      default: r = (kind == KIND_FIVE) ? 7'("V") : (kind == KIND_TEN) ? 7'("X") : 7'("I");
    endcase
    return r;
  endfunction

  assign emit_ok = !out_tvalid_r || out_tready;
  assign sel     = (state_r == nct_pkg::B_IDLE) ? q_cmd : cmd_r;
  assign cur_d   = cmd_r.digits[dig_r];

  // Find leading digit positions and the next Roman decade to emit
  always_comb begin
    dec_top = '0;
    rom_top = '0;
    rom_any = 1'b0;
    rom_low = '0;
    low_any = 1'b0;
    for (int i = 0; i < nct_pkg::DEC_DIGITS; i++) begin
      if (sel.digits[i] != 4'd0) dec_top = 3'(i);
    end
    for (int i = 0; i < 4; i++) begin
      if (sel.digits[i] != 4'd0) begin
        rom_top = 3'(i);
        rom_any = 1'b1;
      end
      if ((3'(i) < dig_r) && (sel.digits[i] != 4'd0)) begin
        rom_low = 3'(i);
        low_any = 1'b1;
      end
    end
  end

  // First state after the sign
  always_comb begin
    entry_state = nct_pkg::B_TERM;
    entry_dig   = rom_top;
    case (sel.style)
      nct_pkg::STYLE_DEC: begin
        entry_state = sel.dec_big ? nct_pkg::B_MARK : nct_pkg::B_DEC;
        entry_dig   = dec_top;
      end
      nct_pkg::STYLE_ROM_UP, nct_pkg::STYLE_ROM_LO: begin
        if (sel.rom_big) entry_state = nct_pkg::B_MARK;
        else if (rom_any) entry_state = nct_pkg::B_ROM;
        else entry_state = nct_pkg::B_TERM;
      end
      nct_pkg::STYLE_LET_UP, nct_pkg::STYLE_LET_LO: entry_state = nct_pkg::B_LET;
      default: entry_state = nct_pkg::B_TERM;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    dig_nxt   = dig_r;
    sub_nxt   = sub_r;
    pos_nxt   = pos_r;
    if (state_r == nct_pkg::B_IDLE) begin
      if (q_valid) begin
        cmd_nxt   = q_cmd;
        pos_nxt   = '0;
        sub_nxt   = '0;
        dig_nxt   = entry_dig;
        state_nxt = q_cmd.neg ? nct_pkg::B_SIGN : entry_state;
      end
    end else if (emit_ok) begin
      pos_nxt = pos_r + 5'd1;
      case (state_r)
        nct_pkg::B_SIGN: begin
          state_nxt = entry_state;
          dig_nxt   = entry_dig;
        end
        nct_pkg::B_MARK: begin
          if (cmd_r.style == nct_pkg::STYLE_DEC) begin
            state_nxt = nct_pkg::B_DEC;
            dig_nxt   = dec_top;
          end else begin
            state_nxt = nct_pkg::B_TERM;
          end
        end
        nct_pkg::B_DEC: begin
          if (dig_r == 3'd0) state_nxt = nct_pkg::B_TERM;
          else dig_nxt = dig_r - 3'd1;
        end
        nct_pkg::B_ROM: begin
          if (({1'b0, sub_r} + 3'd1) == rom_len(cur_d)) begin
            sub_nxt = '0;
            if (low_any) dig_nxt = rom_low;
            else state_nxt = nct_pkg::B_TERM;
          end else begin
            sub_nxt = sub_r + 2'd1;
          end
        end
        nct_pkg::B_LET:  state_nxt = nct_pkg::B_TERM;
        nct_pkg::B_TERM: state_nxt = nct_pkg::B_IDLE;
        default:         state_nxt = nct_pkg::B_IDLE;
      endcase
    end
  end

  assign rom_ch = rom_letter(dig_r[1:0], rom_kind(cur_d, sub_r))
                + ((cmd_r.style == nct_pkg::STYLE_ROM_LO) ? nct_pkg::CASE_OFFSET : 7'd0);

  // Outputs
  always_comb begin
    q_pop = 1'b0;
    emit  = 1'b0;
    ch    = nct_pkg::CH_NUL;
    last  = 1'b0;
    case (state_r)
      nct_pkg::B_IDLE: q_pop = q_valid;
      nct_pkg::B_SIGN: begin
        emit = emit_ok;
        ch   = nct_pkg::CH_MINUS;
      end
      nct_pkg::B_MARK: begin
        emit = emit_ok;
        ch   = nct_pkg::CH_QMARK;
      end
      nct_pkg::B_DEC: begin
        emit = emit_ok;
        ch   = nct_pkg::CH_ZERO + {3'd0, cur_d};
      end
      nct_pkg::B_ROM: begin
        emit = emit_ok;
        ch   = rom_ch;
      end
      nct_pkg::B_LET: begin
        emit = emit_ok;
        ch   = cmd_r.let_code;
      end
      nct_pkg::B_TERM: begin
        emit = emit_ok;
        ch   = nct_pkg::CH_NUL;
        last = 1'b1;
      end
      default: begin
        q_pop = 1'b0;
        emit  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nct_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    dig_r <= dig_nxt;
    sub_r <= sub_nxt;
    pos_r <= pos_nxt;
  end

  // Output register: hold until taken, load on emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_tdata_r <= {4'd0, pos_r, ch};
      out_tlast_r <= last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

/* rtl/core/number_to_counter_text.sv */
// ----------------------------------------------------------------------------
// number_to_counter_text
// Renders a signed 32-bit value as counter text (decimal, Roman, letter) and
// streams it one ASCII character per output word, ending with a NUL word.
// ----------------------------------------------------------------------------
// The front takes one input word at a time: it accepts the word, runs the
// shift-and-add-3 loop that turns the magnitude into five BCD digits (two
// bits per cycle), and hands the command to the queue before it accepts the
// next word. The back emits one character per cycle while the output side
// keeps up, up to 17 words per input (16 characters plus the terminator),
// and takes the next command from the queue when it returns to idle. The
// command queue lets the front convert the next value while the back is still
// emitting.
// ----------------------------------------------------------------------------
module number_to_counter_text #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] value, [34:32] style
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [6:0] char_code, [11:7] position
  output logic        out_tlast   // is_last
);

  logic          push_valid;
  logic          push_ready;
  nct_pkg::cmd_t push_cmd;
  logic          pop_valid;
  logic          pop;
  nct_pkg::cmd_t pop_cmd;

  nct_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  nct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  nct_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (pop_valid),
    .q_cmd      (pop_cmd),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Front goes busy right after taking a word
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("front accepted back-to-back words");

  // Only the terminator carries a NUL character
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[6:0] == nct_pkg::CH_NUL)))
    else $error("terminator flag and NUL character disagree");

  // Text never runs past sixteen characters
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[11:7] < 5'd16))
    else $error("character position out of range");

endmodule

/* tb/nct_checker.sv */
// ----------------------------------------------------------------------------
// nct_checker
// Watches both streams of the counter text converter. Every accepted input
// word is rendered here into the characters the block should emit, and
// every accepted output word is compared with the oldest of those.
// ----------------------------------------------------------------------------
module nct_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,       // [31:0] value, [34:32] style
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,      // [6:0] char_code, [11:7] position
  input  logic        out_tlast,      // is_last
  output int          fail_count,
  output int          expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  // Roman numeral letters, upper case
  localparam logic [6:0] ROM_I = 7'h49;
  localparam logic [6:0] ROM_V = 7'h56;
  localparam logic [6:0] ROM_X = 7'h58;
  localparam logic [6:0] ROM_L = 7'h4C;
  localparam logic [6:0] ROM_C = 7'h43;
  localparam logic [6:0] ROM_D = 7'h44;
  localparam logic [6:0] ROM_M = 7'h4D;

  // Longest string the block can hold, terminator excluded
  localparam int TEXT_CAP = 16;

  typedef struct packed {
    logic [6:0] char_code;
    logic [4:0] position;
    logic       is_last;
  } text_char_t;

  text_char_t char_q[$];

  // Append one character unless the string is full
  function automatic void put_char(ref logic [6:0] txt[$], input logic [6:0] c);
    if (txt.size() < TEXT_CAP)
      txt.push_back(c);
  endfunction

  // Emit one Roman decade: nine, five, four, then repeated ones
  function automatic void put_decade(ref logic [6:0] txt[$], ref int unsigned n,
                                     input int unsigned one,
                                     input logic [6:0] c1, c5, c10);
    if (n >= 9 * one) begin
      put_char(txt, c1);
      put_char(txt, c10);
      n -= 9 * one;
    end else if (n >= 5 * one) begin
      put_char(txt, c5);
      n -= 5 * one;
    end else if (n >= 4 * one) begin
      put_char(txt, c1);
      put_char(txt, c5);
      n -= 4 * one;
    end
    while (n >= one) begin
      put_char(txt, c1);
      n -= one;
    end
  endfunction

  // Render one value in one style and queue its characters plus terminator
  function automatic void render_counter(logic [31:0] raw, logic [2:0] sty);
    logic [6:0]  txt[$];
    logic [6:0]  digs[$];
    logic [31:0] mag;
    int unsigned n;
    int          start;
    text_char_t  ch;

    mag = raw;
    if (raw[31]) begin
      put_char(txt, nct_pkg::CH_MINUS);
      mag = 32'd0 - raw;
    end
    n = mag;

    case (sty)
      nct_pkg::STYLE_DEC: begin
        if (mag >= nct_pkg::DEC_LIMIT) begin
          put_char(txt, nct_pkg::CH_QMARK);
          n = mag % nct_pkg::DEC_LIMIT;
        end
        do begin
          digs.push_back(nct_pkg::CH_ZERO + 7'(n % 10));
          n = n / 10;
        end while (n != 0 && digs.size() < nct_pkg::DEC_DIGITS);
        while (digs.size() > 0)
          put_char(txt, digs.pop_back());
      end
      nct_pkg::STYLE_ROM_UP, nct_pkg::STYLE_ROM_LO: begin
        if (mag >= nct_pkg::ROM_LIMIT) begin
          put_char(txt, nct_pkg::CH_QMARK);
        end else begin
          start = txt.size();
          while (n >= 1000) begin
            put_char(txt, ROM_M);
            n -= 1000;
          end
          put_decade(txt, n, 100, ROM_C, ROM_D, ROM_M);
          put_decade(txt, n, 10, ROM_X, ROM_L, ROM_C);
          put_decade(txt, n, 1, ROM_I, ROM_V, ROM_X);
          if (sty == nct_pkg::STYLE_ROM_LO)
            for (int i = start; i < txt.size(); i++)
              txt[i] = txt[i] + nct_pkg::CASE_OFFSET;
        end
      end
      nct_pkg::STYLE_LET_UP, nct_pkg::STYLE_LET_LO: begin
        if (mag > nct_pkg::LET_MAX)
          put_char(txt, nct_pkg::CH_QMARK);
        else
          put_char(txt, 7'(mag) + ((sty == nct_pkg::STYLE_LET_UP) ?
                                   nct_pkg::LET_UP_BASE : nct_pkg::LET_LO_BASE));
      end
      default: ;  // sign only
    endcase

    foreach (txt[i]) begin
      ch.char_code = txt[i];
      ch.position  = 5'(i);
      ch.is_last   = 1'b0;
      char_q.push_back(ch);
    end
    ch.char_code = nct_pkg::CH_NUL;
    ch.position  = 5'(txt.size());
    ch.is_last   = 1'b1;
    char_q.push_back(ch);
  endfunction

  initial begin
    fail_count    = 0;
    expected_left = 0;
  end

  // Predict on accepted input words, compare accepted output words
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        render_counter(in_tdata[31:0], in_tdata[34:32]);
      if (out_tvalid && out_tready) begin
        if (char_q.size() == 0) begin
          $error("output word with nothing expected: char_code %0d position %0d",
                 out_tdata[6:0], out_tdata[11:7]);
          fail_count++;
        end else begin
          want = char_q.pop_front();
          if (out_tdata[6:0] !== want.char_code) begin
            $error("char_code: expected %0d, actual %0d", want.char_code,
                   out_tdata[6:0]);
            fail_count++;
          end
          if (out_tdata[11:7] !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position,
                   out_tdata[11:7]);
            fail_count++;
          end
          if (out_tlast !== want.is_last) begin
            $error("is_last: expected %0d, actual %0d", want.is_last, out_tlast);
            fail_count++;
          end
        end
      end
      expected_left = char_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives the counter text converter with a directed set of edge values and
// styles, then random values, with random idling on both streams, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] STYLE_SIGN_ONLY = 3'd5;
  localparam logic [2:0] STYLE_MAX       = 3'd7;
  localparam int         RANDOM_WORDS    = 256;
  localparam int         STALL_LIMIT     = 2000;
  localparam int         DRAIN_CYCLES    = 60;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;  // [31:0] value, [34:32] style
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [6:0] char_code, [11:7] position
  logic        out_tlast;        // is_last
  logic        calm       = 1'b0;
  int          fail_count;
  int          expected_left;
  int          idle_cycles = 0;

  always #1 clk = ~clk;

  number_to_counter_text dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  nct_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .expected_left(expected_left)
  );

  // Stall the output side at random, except in the calm stretch
  always @(negedge clk)
    out_tready <= calm || ($urandom_range(99) >= 31);

  // Abort when neither stream moves for too long
  always @(posedge clk) begin
    if (rst_n && !((in_tvalid && in_tready) || (out_tvalid && out_tready)))
      idle_cycles++;
    else
      idle_cycles = 0;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one input word after a random gap; return at the falling edge
  // following its acceptance
  task automatic send_word(logic [31:0] value, logic [2:0] sty);
    while (!calm && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, sty, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Pick a random value: mostly small magnitudes that hit letters, Roman and
  // decimal ranges, sometimes a full 32-bit pattern
  task automatic send_random_word();
    logic [31:0] value;
    logic [2:0]  sty;
    case ($urandom_range(3))
      0:       value = $urandom_range(30);
      1:       value = $urandom_range(4100);
      2:       value = $urandom_range(250000);
      default: value = $urandom;
    endcase
    if ($urandom_range(1))
      value = 32'd0 - value;
    if ($urandom_range(9) < 8)
      sty = 3'($urandom_range(nct_pkg::STYLE_LET_LO));
    else
      sty = 3'($urandom_range(STYLE_MAX));
    send_word(value, sty);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, every style, limits of each range
    send_word(32'd0, nct_pkg::STYLE_DEC);
    send_word(32'hFFFF_FFFF, nct_pkg::STYLE_DEC);
    send_word(32'h7FFF_FFFF, nct_pkg::STYLE_DEC);
    send_word(32'h8000_0000, nct_pkg::STYLE_DEC);
    send_word(32'd99999, nct_pkg::STYLE_DEC);
    send_word(32'd100000, nct_pkg::STYLE_DEC);
    send_word(-32'sd100000, nct_pkg::STYLE_DEC);
    send_word(-32'sd3888, nct_pkg::STYLE_ROM_UP);
    send_word(32'd3888, nct_pkg::STYLE_ROM_LO);
    send_word(32'd3999, nct_pkg::STYLE_ROM_UP);
    send_word(32'd4000, nct_pkg::STYLE_ROM_UP);
    send_word(32'h8000_0000, nct_pkg::STYLE_ROM_UP);
    send_word(32'd0, nct_pkg::STYLE_ROM_UP);
    send_word(-32'sd1994, nct_pkg::STYLE_ROM_LO);
    send_word(32'd1449, nct_pkg::STYLE_ROM_UP);
    send_word(32'd0, nct_pkg::STYLE_LET_UP);
    send_word(32'd0, nct_pkg::STYLE_LET_LO);
    send_word(32'd26, nct_pkg::STYLE_LET_UP);
    send_word(-32'sd26, nct_pkg::STYLE_LET_LO);
    send_word(32'd27, nct_pkg::STYLE_LET_UP);
    send_word(32'h8000_0000, nct_pkg::STYLE_LET_LO);
    for (int s = STYLE_SIGN_ONLY; s <= STYLE_MAX; s++)
      send_word((s == STYLE_MAX) ? 32'h7FFF_FFFF : -32'sd5, 3'(s));

    // Random words, with a stretch where neither side idles
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm <= (i >= 100 && i < 160);
      send_random_word();
    end
    in_tvalid <= 1'b0;
    calm      <= 1'b0;

    // Drain outstanding characters, then allow for stray words
    while (expected_left != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && expected_left == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
